// File: rtl/khs_pkg.sv
package khs_pkg;

    // Store geometry.
    localparam int KEY_DEPTH = 1024;
    localparam int ADDR_W    = $clog2(KEY_DEPTH);
    localparam int COUNT_W   = ADDR_W + 1;

    // Arithmetic widths: Q16.16 operands, 48-bit accumulator.
    localparam int DATA_W = 32;
    localparam int ACC_W  = 48;
    localparam int NUM_W  = DATA_W + 1 + 16;
    localparam int DEN_W  = DATA_W + 1;

    // Item kinds carried in tuser.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_EMPTY  = 2'd1,
        STATUS_SINGLE = 2'd2,
        STATUS_EQUAL  = 2'd3
    } khs_status_t;

    // One keyframe entry of the store.
    typedef struct packed {
        logic [DATA_W-1:0] tangent;
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] ktime;
    } khs_key_t;

    // Divider handshake status.
    typedef struct packed {
        logic busy;
        logic done;
    } khs_div_stat_t;

endpackage

// File: rtl/keyframe_hermite_sampler_top.sv
// A write item leaves the block ready, so it can take a new item in the next cycle.
// An evaluate item goes through a key search that compares keys one at a time through
// the single read port, a wait on the serial divider and three multiply passes; equal key
// times skip the divider, an empty channel skips all of these steps and a single key is
// read once. One item is in work at a time.
// Reset clears control state only; the key store holds undefined data until written.
module keyframe_hermite_sampler_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // key_address, key_time, key_value, key_tangent, channel_start,
    // channel_count, sample_time, one zero pad bit
    input  logic [159:0] s_tdata,
    // cmd
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // sample_value
    output logic [31:0]  m_tdata,
    // status
    output logic [1:0]   m_tuser
);
    import khs_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ONE_RD, ST_ONE_CAP, ST_SRCH_RD, ST_SRCH_CMP,
        ST_SEG_RD0, ST_SEG_RD1, ST_SEG_RD2, ST_COEF, ST_DIV_WAIT,
        ST_MUL_LO, ST_MUL_HI, ST_MUL_SUM, ST_MUL_ACC, ST_FINISH
    } state_t;

    localparam logic [1:0] LAST_STEP = 2'd2;

    state_t state_reg, state_next;

    // Input field unpacking.
    logic [ADDR_W-1:0]        in_addr;
    khs_key_t                 in_key;
    logic [ADDR_W-1:0]        in_start;
    logic [COUNT_W-1:0]       in_count;
    logic signed [DATA_W-1:0] in_sample;
    logic                     accept;

    assign in_addr       = s_tdata[9:0];
    assign in_key.ktime  = s_tdata[41:10];
    assign in_key.value  = s_tdata[73:42];
    assign in_key.tangent = s_tdata[105:74];
    assign in_start      = s_tdata[115:106];
    assign in_count      = s_tdata[126:116];
    assign in_sample     = s_tdata[158:127];
    assign s_tready      = (state_reg == ST_IDLE);
    assign accept        = s_tvalid && s_tready;

    // Working registers.
    logic [ADDR_W-1:0]        start_reg;
    logic [COUNT_W-1:0]       count_reg;
    logic signed [DATA_W-1:0] sample_reg;
    logic [COUNT_W-1:0]       j_reg;
    logic signed [DATA_W-1:0] t0_reg, v0_reg, d0_reg, t1_reg, v1_reg, d1_reg;
    logic signed [DATA_W-1:0] u_reg;
    logic signed [ACC_W-1:0]  acc_reg, cb_reg;
    logic [2*DATA_W-1:0]      plo_reg;
    logic signed [ACC_W-1:0]  prod_reg;
    logic [1:0]               step_reg;
    logic signed [DATA_W-1:0] res_reg;
    khs_status_t              status_reg;
    logic                     m_tvalid_reg;
    logic [DATA_W-1:0]        m_tdata_reg;
    khs_status_t              m_tuser_reg;

    // Key store.
    logic [ADDR_W-1:0] raddr;
    khs_key_t          rdata;

    always_comb
    begin
        unique case (state_reg)
            ST_ONE_RD:  raddr = start_reg;
            ST_SEG_RD0: raddr = start_reg + j_reg[ADDR_W-1:0] - 1'b1;
            default:    raddr = start_reg + j_reg[ADDR_W-1:0];
        endcase
    end

    khs_keystore u_store (
        .clk   (clk),
        .we    (accept && (s_tuser[0] == CMD_WRITE)),
        .waddr (in_addr),
        .wdata (in_key),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Segment differences and Hermite coefficients.
    logic signed [DEN_W-1:0] dt;
    logic signed [DEN_W-1:0] dnum;
    logic signed [ACC_W-1:0] v0x, v1x, d0x, d1x, ca;

    assign dt   = DEN_W'(t1_reg) - DEN_W'(t0_reg);
    assign dnum = DEN_W'(sample_reg) - DEN_W'(t0_reg);
    assign v0x  = ACC_W'(v0_reg);
    assign v1x  = ACC_W'(v1_reg);
    assign d0x  = ACC_W'(d0_reg);
    assign d1x  = ACC_W'(d1_reg);
    assign ca   = ((v0x - v1x) <<< 1) + d0x + d1x;

    // Serial divider for the segment fraction.
    logic signed [DATA_W-1:0] div_quo;
    khs_div_stat_t            div_stat;

    khs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == ST_COEF && dt != '0),
        .num   ({dnum, 16'b0}),
        .den   (dt),
        .quo   (div_quo),
        .stat  (div_stat)
    );

    // Shared multiplier, fed the low then the high half of |acc|.
    logic [ACC_W-1:0]    ma;
    logic [DATA_W-1:0]   mu;
    logic                mneg;
    logic [DATA_W-1:0]   mul_a;
    logic [2*DATA_W-1:0] mul_p;

    assign ma    = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign mu    = u_reg[DATA_W-1] ? DATA_W'(-u_reg) : DATA_W'(u_reg);
    assign mneg  = acc_reg[ACC_W-1] ^ u_reg[DATA_W-1];
    assign mul_a = (state_reg == ST_MUL_HI) ? DATA_W'(ma[ACC_W-1:DATA_W])
                                            : ma[DATA_W-1:0];

    khs_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mu),
        .p   (mul_p)
    );

    // Product rounded toward minus infinity and saturated to 48 bits.
    logic [65:0]             q;
    logic [65:0]             qn;
    logic                    rem;
    logic signed [ACC_W-1:0] prod;

    assign rem = |plo_reg[15:0];
    assign q   = {2'b0, mul_p[ACC_W-1:0], 16'b0} + {18'b0, plo_reg[63:16]};
    assign qn  = q + 66'(rem);

    always_comb
    begin
        if (!mneg)
        begin
            if (|q[65:ACC_W-1])
                prod = {1'b0, {(ACC_W-1){1'b1}}};
            else
                prod = ACC_W'(q);
        end
        else
        begin
            if ((|qn[65:ACC_W]) || (qn[ACC_W-1] && (|qn[ACC_W-2:0])))
                prod = {1'b1, {(ACC_W-1){1'b0}}};
            else
                prod = ACC_W'(-qn);
        end
    end

    // Accumulate with the step's addend and saturate.
    logic signed [ACC_W-1:0] addend;
    logic signed [ACC_W:0]   sum;
    logic signed [ACC_W-1:0] sum48;
    logic signed [DATA_W-1:0] sum32;

    always_comb
    begin
        case (step_reg)
            2'd0:    addend = cb_reg;
            2'd1:    addend = d0x;
            default: addend = v0x;
        endcase
    end

    assign sum = (ACC_W+1)'(prod_reg) + (ACC_W+1)'(addend);

    always_comb
    begin
        if (sum[ACC_W] != sum[ACC_W-1])
            sum48 = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        else
            sum48 = sum[ACC_W-1:0];
        if (!((&sum[ACC_W:DATA_W-1]) || !(|sum[ACC_W:DATA_W-1])))
            sum32 = sum[ACC_W] ? {1'b1, {(DATA_W-1){1'b0}}}
                               : {1'b0, {(DATA_W-1){1'b1}}};
        else
            sum32 = sum[DATA_W-1:0];
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (s_tuser[0] == CMD_EVAL))
                begin
                    if (in_count == '0)
                        state_next = ST_FINISH;
                    else if (in_count == COUNT_W'(1))
                        state_next = ST_ONE_RD;
                    else
                        state_next = ST_SRCH_RD;
                end
            end
            ST_ONE_RD:   state_next = ST_ONE_CAP;
            ST_ONE_CAP:  state_next = ST_FINISH;
            ST_SRCH_RD:  state_next = ST_SRCH_CMP;
            ST_SRCH_CMP:
            begin
                if (j_reg != count_reg - 1'b1
                    && $signed(rdata.ktime) < sample_reg)
                    state_next = ST_SRCH_RD;
                else
                    state_next = ST_SEG_RD0;
            end
            ST_SEG_RD0:  state_next = ST_SEG_RD1;
            ST_SEG_RD1:  state_next = ST_SEG_RD2;
            ST_SEG_RD2:  state_next = ST_COEF;
            ST_COEF:     state_next = (dt == '0) ? ST_MUL_LO : ST_DIV_WAIT;
            ST_DIV_WAIT: state_next = div_stat.done ? ST_MUL_LO : ST_DIV_WAIT;
            ST_MUL_LO:   state_next = ST_MUL_HI;
            ST_MUL_HI:   state_next = ST_MUL_SUM;
            ST_MUL_SUM:  state_next = ST_MUL_ACC;
            ST_MUL_ACC:  state_next = (step_reg == LAST_STEP) ? ST_FINISH : ST_MUL_LO;
            ST_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                    state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // State and output handshake registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            step_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_FINISH && (!m_tvalid_reg || m_tready))
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
            if (state_reg == ST_COEF)
                step_reg <= '0;
            else if (state_reg == ST_MUL_ACC && step_reg != LAST_STEP)
                step_reg <= step_reg + 1'b1;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                start_reg  <= in_start;
                count_reg  <= in_count;
                sample_reg <= in_sample;
                j_reg      <= COUNT_W'(1);
                res_reg    <= '0;
                status_reg <= STATUS_EMPTY;
            end
            ST_ONE_CAP:
            begin
                res_reg    <= rdata.value;
                status_reg <= STATUS_SINGLE;
            end
            ST_SRCH_CMP:
            begin
                if (j_reg != count_reg - 1'b1
                    && $signed(rdata.ktime) < sample_reg)
                    j_reg <= j_reg + 1'b1;
            end
            ST_SEG_RD1:
            begin
                t0_reg <= rdata.ktime;
                v0_reg <= rdata.value;
                d0_reg <= rdata.tangent;
            end
            ST_SEG_RD2:
            begin
                t1_reg <= rdata.ktime;
                v1_reg <= rdata.value;
                d1_reg <= rdata.tangent;
            end
            ST_COEF:
            begin
                acc_reg    <= ca;
                cb_reg     <= (v1x - v0x) + ((v1x - v0x) <<< 1) - (d0x <<< 1) - d1x;
                u_reg      <= '0;
                status_reg <= (dt == '0) ? STATUS_EQUAL : STATUS_OK;
            end
            ST_DIV_WAIT:
            begin
                if (div_stat.done)
                    u_reg <= div_quo;
            end
            ST_MUL_HI:
            begin
                plo_reg <= mul_p;
            end
            ST_MUL_SUM:
            begin
                prod_reg <= prod;
            end
            ST_MUL_ACC:
            begin
                acc_reg <= sum48;
                res_reg <= sum32;
            end
            ST_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tdata_reg <= res_reg;
                    m_tuser_reg <= status_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // The divider only finishes while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == ST_DIV_WAIT)
        else $error("divider finished outside its wait state");

    // A new result only appears after the finishing step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside the finishing step");

    // The search index stays inside the channel.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SRCH_CMP) |-> (j_reg != '0 && j_reg < count_reg))
        else $error("search index left the channel");

    // Exactly three multiply passes: the step never passes the last one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL_ACC && step_reg == LAST_STEP) |=> state_reg == ST_FINISH)
        else $error("multiply sequence overran");

endmodule

// File: rtl/khs_keystore.sv
module khs_keystore (
    input  logic                      clk,
    input  logic                      we,
    input  logic [khs_pkg::ADDR_W-1:0] waddr,
    input  khs_pkg::khs_key_t         wdata,
    input  logic [khs_pkg::ADDR_W-1:0] raddr,
    output khs_pkg::khs_key_t         rdata
);
    import khs_pkg::*;

    khs_key_t mem [KEY_DEPTH];
    khs_key_t rdata_reg;

    // Single write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Single registered read port.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/khs_mul.sv
module khs_mul (
    input  logic                        clk,
    input  logic [khs_pkg::DATA_W-1:0]   a,
    input  logic [khs_pkg::DATA_W-1:0]   b,
    output logic [2*khs_pkg::DATA_W-1:0] p
);
    import khs_pkg::*;

    logic [2*DATA_W-1:0] p_reg;

    // Unsigned 32 by 32 product, registered.
    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

// File: rtl/khs_div.sv
module khs_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [khs_pkg::NUM_W-1:0]  num,
    input  logic signed [khs_pkg::DEN_W-1:0]  den,
    output logic signed [khs_pkg::DATA_W-1:0] quo,
    output khs_pkg::khs_div_stat_t            stat
);
    import khs_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] numq_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             neg_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   rem_shift;
    logic [DEN_W:0]   rem_diff;
    logic             fits;

    // One quotient bit per cycle, restoring on magnitudes.
    assign rem_shift = {rem_reg, numq_reg[NUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, den_reg};
    assign fits      = !rem_diff[DEN_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            numq_reg <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            den_reg  <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
            neg_reg  <= num[NUM_W-1] ^ den[DEN_W-1];
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? rem_diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
            numq_reg <= {numq_reg[NUM_W-2:0], fits};
        end
    end

    // Truncated quotient, saturated to the signed Q16.16 range.
    always_comb
    begin
        if (!neg_reg)
        begin
            if (|numq_reg[NUM_W-1:DATA_W-1])
                quo = {1'b0, {(DATA_W-1){1'b1}}};
            else
                quo = DATA_W'(numq_reg);
        end
        else
        begin
            if ((|numq_reg[NUM_W-1:DATA_W])
                || (numq_reg[DATA_W-1] && (|numq_reg[DATA_W-2:0])))
                quo = {1'b1, {(DATA_W-1){1'b0}}};
            else
                quo = DATA_W'(-numq_reg);
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// File: bench/keyframe_hermite_sampler_top_test.sv
module keyframe_hermite_sampler_top_test;

    import khs_pkg::*;

    localparam longint ACC_MAX  = 64'sd140737488355327;
    localparam longint ACC_MIN  = -ACC_MAX - 1;
    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -WORD_MAX - 1;
    localparam int     DRAIN_CYCLES = 3000;
    localparam int     HOLD_CYCLES  = 3000;
    localparam int     FILL_KEYS    = 432;

    typedef struct {
        logic               cmd;
        logic [ADDR_W-1:0]  key_address;
        logic [31:0]        key_time;
        logic [31:0]        key_value;
        logic [31:0]        key_tangent;
        logic [ADDR_W-1:0]  channel_start;
        logic [COUNT_W-1:0] channel_count;
        logic [31:0]        sample_time;
    } key_item_t;

    typedef struct {
        logic [31:0] value;
        khs_status_t status;
    } sample_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [159:0] s_tdata;
    logic [0:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [31:0]  m_tdata;
    logic [1:0]   m_tuser;

    keyframe_hermite_sampler_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Items waiting to be offered, and samples waiting to come back.
    key_item_t pending_items[$];
    sample_t   expected_samples[$];
    int        error_count = 0;
    int        accepted_count = 0;
    bit        stimulus_done = 0;

    // Predictor copy of the key store.
    logic [31:0] pred_time[KEY_DEPTH];
    logic [31:0] pred_value[KEY_DEPTH];
    logic [31:0] pred_tangent[KEY_DEPTH];

    // Generator shadow: which entries hold data, and their times.
    bit          gen_written[KEY_DEPTH];
    int          gen_time[KEY_DEPTH];

    // Clock and reset.
    initial begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Overall time limit.
    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic longint widen(logic [31:0] x);
        return longint'($signed(x));
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Q16.16 product, floored at 16 fraction bits and held to 48 bits.
    function automatic longint scale_q16(longint acc, longint u);
        logic signed [95:0] a;
        logic signed [95:0] b;
        logic signed [95:0] p;
        a = 96'(acc);
        b = 96'(u);
        p = (a * b) >>> 16;
        if (p > ACC_MAX)
            return ACC_MAX;
        if (p < ACC_MIN)
            return ACC_MIN;
        return longint'(p);
    endfunction

    // Applies one accepted item to the store copy and predicts its sample.
    function automatic void predict_sample(key_item_t it);
        sample_t     s;
        int unsigned j;
        int unsigned a0;
        int unsigned a1;
        int unsigned cnt;
        longint      t;
        longint      t0;
        longint      t1;
        longint      v0;
        longint      v1;
        longint      d0;
        longint      d1;
        longint      u;
        longint      ca;
        longint      cb;
        longint      acc;
        if (it.cmd == CMD_WRITE) begin
            pred_time[it.key_address]    = it.key_time;
            pred_value[it.key_address]   = it.key_value;
            pred_tangent[it.key_address] = it.key_tangent;
            return;
        end
        cnt = 32'(it.channel_count);
        t   = widen(it.sample_time);
        s.status = STATUS_OK;
        if (cnt == 0) begin
            s.value  = '0;
            s.status = STATUS_EMPTY;
        end else if (cnt == 1) begin
            s.value  = pred_value[it.channel_start];
            s.status = STATUS_SINGLE;
        end else begin
            // Walk to the first key from the second on that is not early.
            j = 1;
            while (j < cnt - 1 &&
                   widen(pred_time[(it.channel_start + j) % KEY_DEPTH]) < t)
                j++;
            a0 = (it.channel_start + j - 1) % KEY_DEPTH;
            a1 = (it.channel_start + j) % KEY_DEPTH;
            t0 = widen(pred_time[a0]);
            t1 = widen(pred_time[a1]);
            v0 = widen(pred_value[a0]);
            v1 = widen(pred_value[a1]);
            d0 = widen(pred_tangent[a0]);
            d1 = widen(pred_tangent[a1]);
            if (t1 == t0) begin
                u = 0;
                s.status = STATUS_EQUAL;
            end else begin
                u = clamp(((t - t0) * 65536) / (t1 - t0), WORD_MIN, WORD_MAX);
            end
            ca  = 2 * (v0 - v1) + d0 + d1;
            cb  = -3 * v0 + 3 * v1 - 2 * d0 - d1;
            acc = clamp(ca, ACC_MIN, ACC_MAX);
            acc = clamp(scale_q16(acc, u) + cb, ACC_MIN, ACC_MAX);
            acc = clamp(scale_q16(acc, u) + d0, ACC_MIN, ACC_MAX);
            acc = clamp(scale_q16(acc, u) + v0, WORD_MIN, WORD_MAX);
            s.value = acc[31:0];
        end
        expected_samples.push_back(s);
    endfunction

    // Sender: offers queued items, idling at the current rate.
    key_item_t offered;
    int        send_idle_pct;
    int        recv_idle_pct;

    always_comb
    begin
        if (accepted_count < 350) begin
            send_idle_pct = 17;
            recv_idle_pct = 85;
        end else if (accepted_count < 700) begin
            send_idle_pct = 85;
            recv_idle_pct = 17;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= CMD_WRITE;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_sample(offered);
                accepted_count++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= offered.cmd;
                    s_tdata  <= {1'b0, offered.sample_time, offered.channel_count,
                                 offered.channel_start, offered.key_tangent,
                                 offered.key_value, offered.key_time,
                                 offered.key_address};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off.
    int hold_left = 0;
    bit hold_done = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else if (!hold_done && accepted_count >= 200) begin
            hold_done = 1;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Checker: compares each returned sample with the oldest prediction.
    always @(posedge clk)
    begin
        sample_t s;
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_samples.size() == 0) begin
                $error("unexpected sample: sample_value %h status %0d", m_tdata, m_tuser);
                error_count++;
            end else begin
                s = expected_samples.pop_front();
                if (m_tdata !== s.value) begin
                    $error("sample_value: expected %h, actual %h", s.value, m_tdata);
                    error_count++;
                end
                if (m_tuser !== s.status) begin
                    $error("status: expected %0d, actual %0d", s.status, m_tuser);
                    error_count++;
                end
            end
        end
    end

    // Stimulus helpers.
    task automatic add_write(int unsigned adr, int t, int v, int d);
        key_item_t it;
        it = '{default: '0};
        it.cmd         = CMD_WRITE;
        it.key_address = ADDR_W'(adr);
        it.key_time    = t;
        it.key_value   = v;
        it.key_tangent = d;
        pending_items.push_back(it);
        gen_written[adr % KEY_DEPTH] = 1;
        gen_time[adr % KEY_DEPTH]    = t;
    endtask

    task automatic add_eval(int unsigned start, int unsigned cnt, int st);
        key_item_t it;
        it = '{default: '0};
        it.cmd           = CMD_EVAL;
        it.channel_start = ADDR_W'(start);
        it.channel_count = COUNT_W'(cnt);
        it.sample_time   = st;
        it.key_address   = ADDR_W'($urandom);
        pending_items.push_back(it);
    endtask

    function automatic bit channel_ready(int unsigned start, int unsigned cnt);
        for (int unsigned k = 0; k < cnt; k++)
            if (!gen_written[(start + k) % KEY_DEPTH])
                return 0;
        return 1;
    endfunction

    function automatic int pick_value();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return $signed($urandom_range(32'h7FFF_FFFF, 32'h7FF0_0000))
                            * ($urandom_range(1) ? 1 : -1);
            default: return int'($urandom_range(32'h0020_0000)) - 32'h0010_0000;
        endcase
    endfunction

    // Sample time around a channel, sometimes on a key or far outside.
    function automatic int pick_sample(int unsigned start, int unsigned cnt);
        int lo;
        int hi;
        lo = gen_time[start % KEY_DEPTH];
        hi = gen_time[(start + cnt - 1) % KEY_DEPTH];
        if (lo > hi) begin
            lo = hi;
            hi = gen_time[start % KEY_DEPTH];
        end
        case ($urandom_range(9))
            0:       return $urandom;
            1:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2:       return gen_time[(start + $urandom_range(cnt - 1)) % KEY_DEPTH];
            default: return int'(longint'(lo) - 32'h8000
                            + longint'($urandom_range(32'(longint'(hi) - lo + 32'h10000))));
        endcase
    endfunction

    // Writes a channel of keys with non-decreasing times and samples it a few times.
    task automatic add_channel();
        int unsigned start;
        int unsigned n;
        int          t;
        start = $urandom_range(KEY_DEPTH - 1);
        n     = $urandom_range(8, 2);
        t     = int'($urandom_range(32'h4000_0000)) - 32'h2000_0000;
        for (int unsigned k = 0; k < n; k++) begin
            add_write((start + k) % KEY_DEPTH, t, pick_value(), pick_value());
            if ($urandom_range(9) == 0)
                t = t;
            else
                t = t + $urandom_range(32'h0004_0000, 1);
        end
        repeat ($urandom_range(5, 2))
            add_eval(start, $urandom_range(n, 1), pick_sample(start, n));
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || s_tvalid || expected_samples.size() > 0)
            @(posedge clk);
    endtask

    // Stimulus: directed cases, random channels, then a long ascending run.
    initial begin
        int unsigned start;
        int unsigned cnt;
        @(posedge rst_n);

        // Channel that wraps past the end of the store, with extreme values.
        add_write(1022, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        add_write(1023, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        add_write(0,    32'h0000_0000, 32'h0001_0000, 32'h0000_0000);
        add_write(1,    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_eval(500, 0, 32'h1234_5678);
        add_eval(1023, 1, 32'h0);
        add_eval(1022, 4, 32'h8000_0000);
        add_eval(1022, 4, 32'h7FFF_FFFF);
        add_eval(1022, 4, 32'hC000_0000);
        // Equal key times between entries 1023 and 0.
        add_eval(1023, 2, 32'h0000_0000);
        add_eval(1023, 3, 32'h0000_8000);
        add_eval(0, 2, 32'h4000_0000);
        add_eval(1022, 2, 32'h8000_0001);
        // A gentle segment with exact midpoint.
        add_write(2, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
        add_write(3, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000);
        add_eval(2, 2, 32'h0000_8000);
        add_eval(2, 2, 32'hFFFF_0000);
        add_eval(2, 2, 32'h0003_0000);
        wait_drained();

        // Random channels with some noise between them.
        while (accepted_count + pending_items.size() < 600) begin
            case ($urandom_range(9))
                0: add_write($urandom_range(KEY_DEPTH - 1), $urandom, $urandom, $urandom);
                1: begin
                    start = $urandom_range(KEY_DEPTH - 1);
                    cnt   = $urandom_range(3);
                    if (channel_ready(start, cnt))
                        add_eval(start, cnt, $urandom);
                end
                default: add_channel();
            endcase
            if (pending_items.size() > 40)
                while (pending_items.size() > 10)
                    @(posedge clk);
        end
        wait_drained();

        // Lower part of the store written with ascending times, then long channels over it.
        for (int unsigned k = 0; k < FILL_KEYS; k++)
            add_write(k, 32'h8010_0000 + k * 32'h0010_0000, pick_value(), pick_value());
        add_eval(0, FILL_KEYS, $urandom);
        add_eval(117, FILL_KEYS - 117, 32'h7FFF_FFFF);
        add_eval(1, FILL_KEYS - 1, 32'h8000_0000);
        repeat (8) begin
            start = $urandom_range(FILL_KEYS - 1);
            add_eval(start, $urandom_range(FILL_KEYS - start), $urandom);
        end
        stimulus_done = 1;
    end

    // End of run.
    initial begin
        @(posedge rst_n);
        while (!(stimulus_done && pending_items.size() == 0 && !s_tvalid
                 && expected_samples.size() == 0))
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_samples.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: files.f
rtl/khs_pkg.sv
rtl/khs_keystore.sv
rtl/khs_mul.sv
rtl/khs_div.sv
rtl/keyframe_hermite_sampler_top.sv
bench/keyframe_hermite_sampler_top_test.sv
